@@ hw/rtl/pal_pkg.sv @@
// shared types and constants for the positional array list
// used by pal_ctrl, pal_dp, positional_array_list and the testbench; no other dependencies
package pal_pkg;

    // fixed field widths
    localparam int CMD_W  = 2;
    localparam int POS_W  = 5;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 5;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_DONE
    } t_state;

    // memory read address select
    typedef enum logic [1:0] {
        RD_POS,
        RD_PREV,
        RD_NEXT
    } t_rd_sel;

    // memory write address and data select
    typedef enum logic [1:0] {
        WR_POS_VAL,
        WR_CNT_VAL,
        WR_IDX_RDATA
    } t_wr_sel;

    // controller to datapath commands
    typedef struct packed {
        logic    load;
        logic    set_err;
        logic    idx_init_cnt;
        logic    idx_init_pos;
        logic    idx_inc;
        logic    idx_dec;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    hold_load;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    out_load;
    } t_ctrl;

    // datapath to controller status
    typedef struct packed {
        t_cmd cmd;
        logic err;
        logic ins_more;
        logic del_more;
        logic out_free;
    } t_stat;

endpackage

@@ hw/rtl/pal_ctrl.sv @@
// sequencing state machine for the positional array list
// depends on pal_pkg; drives the command struct into pal_dp
module pal_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  pal_pkg::t_stat i_stat,
    output pal_pkg::t_ctrl o_ctrl,
    output logic           o_stall
);

    pal_pkg::t_state r_state;
    pal_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pal_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pal_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = pal_pkg::S_EXEC;
                end
            end
            pal_pkg::S_EXEC: begin
                if (i_stat.err) begin
                    n_state = pal_pkg::S_DONE;
                end else begin
                    case (i_stat.cmd)
                        pal_pkg::CMD_INSERT: n_state = pal_pkg::S_INS_RD;
                        pal_pkg::CMD_APPEND: n_state = pal_pkg::S_DONE;
                        default:             n_state = pal_pkg::S_FETCH;
                    endcase
                end
            end
            pal_pkg::S_FETCH: begin
                if (i_stat.cmd == pal_pkg::CMD_DELETE) begin
                    n_state = pal_pkg::S_DEL_RD;
                end else begin
                    n_state = pal_pkg::S_DONE;
                end
            end
            pal_pkg::S_INS_RD: begin
                if (i_stat.ins_more) begin
                    n_state = pal_pkg::S_INS_WR;
                end else begin
                    n_state = pal_pkg::S_DONE;
                end
            end
            pal_pkg::S_INS_WR: n_state = pal_pkg::S_INS_RD;
            pal_pkg::S_DEL_RD: begin
                if (i_stat.del_more) begin
                    n_state = pal_pkg::S_DEL_WR;
                end else begin
                    n_state = pal_pkg::S_DONE;
                end
            end
            pal_pkg::S_DEL_WR: n_state = pal_pkg::S_DEL_RD;
            pal_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = pal_pkg::S_IDLE;
                end
            end
            default: n_state = pal_pkg::S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_ctrl  = '0;
        o_stall = 1'b1;
        case (r_state)
            pal_pkg::S_IDLE: begin
                o_stall     = 1'b0;
                o_ctrl.load = i_valid;
            end
            pal_pkg::S_EXEC: begin
                o_ctrl.set_err = 1'b1;
                if (!i_stat.err) begin
                    case (i_stat.cmd)
                        pal_pkg::CMD_INSERT: o_ctrl.idx_init_cnt = 1'b1;
                        pal_pkg::CMD_APPEND: begin
                            o_ctrl.wr_en   = 1'b1;
                            o_ctrl.wr_sel  = pal_pkg::WR_CNT_VAL;
                            o_ctrl.cnt_inc = 1'b1;
                        end
                        default: begin
                            o_ctrl.rd_en        = 1'b1;
                            o_ctrl.rd_sel       = pal_pkg::RD_POS;
                            o_ctrl.idx_init_pos = 1'b1;
                        end
                    endcase
                end
            end
            pal_pkg::S_FETCH: o_ctrl.hold_load = 1'b1;
            pal_pkg::S_INS_RD: begin
                if (i_stat.ins_more) begin
                    o_ctrl.rd_en  = 1'b1;
                    o_ctrl.rd_sel = pal_pkg::RD_PREV;
                end else begin
                    o_ctrl.wr_en   = 1'b1;
                    o_ctrl.wr_sel  = pal_pkg::WR_POS_VAL;
                    o_ctrl.cnt_inc = 1'b1;
                end
            end
            pal_pkg::S_INS_WR: begin
                o_ctrl.wr_en   = 1'b1;
                o_ctrl.wr_sel  = pal_pkg::WR_IDX_RDATA;
                o_ctrl.idx_dec = 1'b1;
            end
            pal_pkg::S_DEL_RD: begin
                if (i_stat.del_more) begin
                    o_ctrl.rd_en  = 1'b1;
                    o_ctrl.rd_sel = pal_pkg::RD_NEXT;
                end else begin
                    o_ctrl.cnt_dec = 1'b1;
                end
            end
            pal_pkg::S_DEL_WR: begin
                o_ctrl.wr_en   = 1'b1;
                o_ctrl.wr_sel  = pal_pkg::WR_IDX_RDATA;
                o_ctrl.idx_inc = 1'b1;
            end
            pal_pkg::S_DONE: o_ctrl.out_load = i_stat.out_free;
            default: o_ctrl = '0;
        endcase
    end

endmodule

@@ hw/rtl/pal_dp.sv @@
// datapath of the positional array list: item memory, count, index and result register
// depends on pal_pkg; steered by pal_ctrl
module pal_dp #(
    parameter int DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pal_pkg::t_ctrl                    i_ctrl,
    output pal_pkg::t_stat                    o_stat,
    input  logic [pal_pkg::CMD_W-1:0]         i_cmd,
    input  logic [pal_pkg::POS_W-1:0]         i_position,
    input  logic signed [pal_pkg::DATA_W-1:0] i_item_value,
    input  logic                              i_stall,
    output logic                              o_valid,
    output logic signed [pal_pkg::DATA_W-1:0] o_data_out,
    output logic                              o_error,
    output logic [pal_pkg::CNT_W-1:0]         o_item_count,
    output logic                              o_full_res,
    output logic                              o_empty_res
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > pal_pkg::POS_W) ? CW : pal_pkg::POS_W;

    logic [pal_pkg::DATA_W-1:0] mem [DEPTH];

    pal_pkg::t_cmd              r_cmd;
    logic [pal_pkg::POS_W-1:0]  r_pos;
    logic [pal_pkg::DATA_W-1:0] r_val;
    logic [CW-1:0]              r_count;
    logic [AW-1:0]              r_idx;
    logic [pal_pkg::DATA_W-1:0] r_rdata;
    logic [pal_pkg::DATA_W-1:0] r_hold;
    logic                       r_err;
    logic                       r_out_valid;
    logic [pal_pkg::DATA_W-1:0] r_out_data;
    logic                       r_out_err;
    logic [pal_pkg::CNT_W-1:0]  r_out_cnt;
    logic                       r_out_full;
    logic                       r_out_empty;

    logic [CMPW-1:0]            w_pos_ext;
    logic [CMPW-1:0]            w_cnt_ext;
    logic [CMPW-1:0]            w_idx_ext;
    logic [AW-1:0]              w_pos_addr;
    logic                       w_full;
    logic                       w_err;
    logic [AW-1:0]              w_rd_addr;
    logic [AW-1:0]              w_wr_addr;
    logic [pal_pkg::DATA_W-1:0] w_wr_data;
    logic                       w_out_free;
    logic                       w_has_data;

    // widened operands for compares
    assign w_pos_ext  = CMPW'(r_pos);
    assign w_cnt_ext  = CMPW'(r_count);
    assign w_idx_ext  = CMPW'(r_idx);
    assign w_pos_addr = w_pos_ext[AW-1:0];
    assign w_full     = (r_count == CW'(DEPTH));

    // command legality
    always_comb begin
        case (r_cmd)
            pal_pkg::CMD_INSERT: w_err = w_full || (w_pos_ext > w_cnt_ext);
            pal_pkg::CMD_APPEND: w_err = w_full;
            default:             w_err = (w_pos_ext >= w_cnt_ext);
        endcase
    end

    assign w_out_free = !r_out_valid || !i_stall;

    assign o_stat.cmd      = r_cmd;
    assign o_stat.err      = w_err;
    assign o_stat.ins_more = (w_idx_ext > w_pos_ext);
    assign o_stat.del_more = ((w_idx_ext + CMPW'(1)) < w_cnt_ext);
    assign o_stat.out_free = w_out_free;

    // read address select
    always_comb begin
        case (i_ctrl.rd_sel)
            pal_pkg::RD_PREV: w_rd_addr = r_idx - AW'(1);
            pal_pkg::RD_NEXT: w_rd_addr = r_idx + AW'(1);
            default:          w_rd_addr = w_pos_addr;
        endcase
    end

    // write address and data select
    always_comb begin
        case (i_ctrl.wr_sel)
            pal_pkg::WR_CNT_VAL: begin
                w_wr_addr = r_count[AW-1:0];
                w_wr_data = r_val;
            end
            pal_pkg::WR_IDX_RDATA: begin
                w_wr_addr = r_idx;
                w_wr_data = r_rdata;
            end
            default: begin
                w_wr_addr = w_pos_addr;
                w_wr_data = r_val;
            end
        endcase
    end

    // item memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_rdata <= mem[w_rd_addr];
        end
    end

    // captured item, index, held data, error flag
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd <= pal_pkg::t_cmd'(i_cmd);
            r_pos <= i_position;
            r_val <= i_item_value;
        end
        if (i_ctrl.set_err) begin
            r_err <= w_err;
        end
        if (i_ctrl.hold_load) begin
            r_hold <= r_rdata;
        end
        if (i_ctrl.idx_init_cnt) begin
            r_idx <= r_count[AW-1:0];
        end else if (i_ctrl.idx_init_pos) begin
            r_idx <= w_pos_addr;
        end else if (i_ctrl.idx_inc) begin
            r_idx <= r_idx + AW'(1);
        end else if (i_ctrl.idx_dec) begin
            r_idx <= r_idx - AW'(1);
        end
    end

    // item count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctrl.cnt_inc) begin
            r_count <= r_count + CW'(1);
        end else if (i_ctrl.cnt_dec) begin
            r_count <= r_count - CW'(1);
        end
    end

    // result register
    assign w_has_data = !r_err && (r_cmd == pal_pkg::CMD_DELETE || r_cmd == pal_pkg::CMD_READ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            r_out_data  <= w_has_data ? r_hold : '0;
            r_out_err   <= r_err;
            r_out_cnt   <= w_cnt_ext[pal_pkg::CNT_W-1:0];
            r_out_full  <= w_full;
            r_out_empty <= (r_count == '0);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_data_out   = r_out_data;
    assign o_error      = r_out_err;
    assign o_item_count = r_out_cnt;
    assign o_full_res   = r_out_full;
    assign o_empty_res  = r_out_empty;

endmodule

@@ hw/rtl/positional_array_list.sv @@
// top level of the positional array list: ordered list with insert, append, delete, read
// depends on pal_pkg, pal_ctrl and pal_dp
//
// channel  | valid    | stall    | payload
// ---------+----------+----------+---------------------------------------------------
// command  | i_valid  | o_stall  | i_cmd, i_position, i_item_value
// result   | o_valid  | i_stall  | o_data_out, o_error, o_item_count, o_full_res,
//          |          |          | o_empty_res
//
// one item at a time; the list lives in a single-port-write, registered-read memory,
// so each shifted entry is first read, then written back
// append and refused commands go from execute straight to done; read adds a fetch;
// insert shifts the entries from p to the end up, delete fetches then shifts them down
// reset (synchronous, active low) empties the list; entries need no clearing pass
// a result waits in the output register under i_stall while the next item is taken
module positional_array_list #(
    parameter int DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [pal_pkg::CMD_W-1:0]         i_cmd,
    input  logic [pal_pkg::POS_W-1:0]         i_position,
    input  logic signed [pal_pkg::DATA_W-1:0] i_item_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [pal_pkg::DATA_W-1:0] o_data_out,
    output logic                              o_error,
    output logic [pal_pkg::CNT_W-1:0]         o_item_count,
    output logic                              o_full_res,
    output logic                              o_empty_res
);

    pal_pkg::t_ctrl w_ctrl;
    pal_pkg::t_stat w_stat;

    // sequencer
    pal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl),
        .o_stall (o_stall)
    );

    // storage and result datapath
    pal_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .o_stat       (w_stat),
        .i_cmd        (i_cmd),
        .i_position   (i_position),
        .i_item_value (i_item_value),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_data_out   (o_data_out),
        .o_error      (o_error),
        .o_item_count (o_item_count),
        .o_full_res   (o_full_res),
        .o_empty_res  (o_empty_res)
    );

endmodule

@@ tb/list_result_checker.sv @@
// result checker for the positional array list: mirrors the list, predicts each result
// depends on pal_pkg; watches both channels of positional_array_list from outside
module list_result_checker #(
    parameter int DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cmd_valid,
    input  logic                              i_cmd_stall,
    input  logic [pal_pkg::CMD_W-1:0]         i_cmd,
    input  logic [pal_pkg::POS_W-1:0]         i_position,
    input  logic signed [pal_pkg::DATA_W-1:0] i_item_value,
    input  logic                              i_res_valid,
    input  logic                              i_res_stall,
    input  logic signed [pal_pkg::DATA_W-1:0] i_data_out,
    input  logic                              i_error,
    input  logic [pal_pkg::CNT_W-1:0]         i_item_count,
    input  logic                              i_full_res,
    input  logic                              i_empty_res,
    output int                                o_mismatches,
    output int                                o_pending
);
    import pal_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              error;
        logic [CNT_W-1:0]  count;
        logic              full;
        logic              empty;
    } t_list_result;

    // mirrored list contents and length
    logic [DATA_W-1:0] list_mem [DEPTH];
    int                list_len = 0;

    t_list_result expected_results [$];
    int           mismatch_count = 0;
    int           result_index   = 0;

    // apply one command to the mirrored list and form its result
    function automatic t_list_result apply_command(t_cmd c, logic [POS_W-1:0] p,
                                                   logic [DATA_W-1:0] v);
        t_list_result r;
        int           k;
        int           pi;
        r  = '0;
        pi = int'(p);
        case (c)
            CMD_INSERT: begin
                if (list_len >= DEPTH || pi > list_len) begin
                    r.error = 1'b1;
                end else begin
                    for (k = list_len; k > pi; k--)
                        list_mem[k] = list_mem[k-1];
                    list_mem[pi] = v;
                    list_len++;
                end
            end
            CMD_APPEND: begin
                if (list_len >= DEPTH) begin
                    r.error = 1'b1;
                end else begin
                    list_mem[list_len] = v;
                    list_len++;
                end
            end
            CMD_DELETE: begin
                if (pi >= list_len) begin
                    r.error = 1'b1;
                end else begin
                    r.data = list_mem[pi];
                    for (k = pi; k + 1 < list_len; k++)
                        list_mem[k] = list_mem[k+1];
                    list_len--;
                end
            end
            default: begin
                if (pi >= list_len)
                    r.error = 1'b1;
                else
                    r.data = list_mem[pi];
            end
        endcase
        r.count = CNT_W'(list_len);
        r.full  = (list_len == DEPTH);
        r.empty = (list_len == 0);
        return r;
    endfunction

    // compare accepted results first, then record the item taken at this edge
    always @(posedge i_clk) begin
        t_list_result want;
        t_list_result got;
        if (i_rst_n) begin
            if (i_res_valid && !i_res_stall) begin
                got = '{i_data_out, i_error, i_item_count, i_full_res, i_empty_res};
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d: no item pending, got data %0d err %0b",
                                 result_index, $signed(got.data), got.error);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("result %0d: expected data %0d err %0b cnt %0d full %0b empty %0b",
                                     result_index, $signed(want.data), want.error,
                                     want.count, want.full, want.empty);
                            $display("result %0d: got data %0d err %0b cnt %0d full %0b empty %0b",
                                     result_index, $signed(got.data), got.error,
                                     got.count, got.full, got.empty);
                        end
                    end
                end
                result_index++;
            end
            if (i_cmd_valid && !i_cmd_stall)
                expected_results.push_back(apply_command(t_cmd'(i_cmd), i_position,
                                                         i_item_value));
        end
        o_mismatches <= mismatch_count;
        o_pending    <= expected_results.size();
    end

endmodule

@@ tb/positional_array_list_tb.sv @@
// testbench top for positional_array_list: reset, directed and random commands, verdict
// depends on pal_pkg, positional_array_list and list_result_checker
module positional_array_list_tb;
    import pal_pkg::*;

    localparam int DEPTH = 16;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_valid      = 1'b0;
    logic [CMD_W-1:0]         i_cmd        = '0;
    logic [POS_W-1:0]         i_position   = '0;
    logic signed [DATA_W-1:0] i_item_value = '0;
    logic                     i_stall      = 1'b0;
    logic                     o_stall;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_data_out;
    logic                     o_error;
    logic [CNT_W-1:0]         o_item_count;
    logic                     o_full_res;
    logic                     o_empty_res;

    int mismatches;
    int pending;

    // stimulus shaping state
    int shadow_len = 0;
    int burst_left = 1;
    int stall_tick = 0;
    int stall_mode = 0;

    always #1 i_clk = ~i_clk;

    positional_array_list #(.DEPTH(DEPTH)) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_position   (i_position),
        .i_item_value (i_item_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_data_out   (o_data_out),
        .o_error      (o_error),
        .o_item_count (o_item_count),
        .o_full_res   (o_full_res),
        .o_empty_res  (o_empty_res)
    );

    list_result_checker #(.DEPTH(DEPTH)) result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (i_valid),
        .i_cmd_stall  (o_stall),
        .i_cmd        (i_cmd),
        .i_position   (i_position),
        .i_item_value (i_item_value),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_data_out   (o_data_out),
        .i_error      (o_error),
        .i_item_count (o_item_count),
        .i_full_res   (o_full_res),
        .i_empty_res  (o_empty_res),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // receiver stall pattern: a randomly picked mode of none, light, heavy or periodic stalls
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 97 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 3) == 0);
            2:       i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= ((stall_tick / 6) % 2 == 1);
        endcase
    end

    // present one item, hold it until taken, then maybe leave a gap
    task automatic send_item(t_cmd c, logic [POS_W-1:0] p, logic [DATA_W-1:0] v);
        int gap;
        i_valid      <= 1'b1;
        i_cmd        <= c;
        i_position   <= p;
        i_item_value <= v;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        // track the length only to steer positions toward the valid range
        case (c)
            CMD_INSERT: if (shadow_len < DEPTH && int'(p) <= shadow_len) shadow_len++;
            CMD_APPEND: if (shadow_len < DEPTH) shadow_len++;
            CMD_DELETE: if (int'(p) < shadow_len) shadow_len--;
            default: ;
        endcase
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // mostly inside the valid span, sometimes anywhere in the field
    function automatic logic [POS_W-1:0] pick_position(int span);
        if (span > 0 && $urandom_range(0, 9) < 8)
            return POS_W'($urandom_range(0, span - 1));
        return POS_W'($urandom_range(0, 31));
    endfunction

    // stimulus and verdict
    initial begin
        int   n;
        int   seg_left;
        int   mode;
        int   r;
        int   waited;
        t_cmd c;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty list refusals, extremes, front/middle/end edits
        send_item(CMD_READ,   5'd0,  32'h1234_5678);
        send_item(CMD_DELETE, 5'd0,  32'h0);
        send_item(CMD_INSERT, 5'd1,  32'h5555_5555);
        send_item(CMD_INSERT, 5'd0,  32'h8000_0000);
        send_item(CMD_APPEND, 5'd31, 32'h7fff_ffff);
        send_item(CMD_INSERT, 5'd0,  32'hffff_ffff);
        send_item(CMD_INSERT, 5'd1,  32'h0000_0000);
        send_item(CMD_INSERT, 5'd4,  32'haaaa_aaaa);
        send_item(CMD_READ,   5'd0,  32'h0);
        send_item(CMD_READ,   5'd4,  32'h0);
        send_item(CMD_READ,   5'd5,  32'h0);
        send_item(CMD_READ,   5'd31, 32'h0);
        send_item(CMD_DELETE, 5'd16, 32'h0);
        send_item(CMD_DELETE, 5'd1,  32'h0);
        send_item(CMD_DELETE, 5'd3,  32'h0);
        send_item(CMD_DELETE, 5'd0,  32'h0);
        send_item(CMD_INSERT, 5'd3,  32'h0f0f_0f0f);
        send_item(CMD_INSERT, 5'd17, 32'hf0f0_f0f0);

        // random: segments that grow, shrink or mix the list
        seg_left = 0;
        mode     = 0;
        for (n = 0; n < 400; n++) begin
            if (seg_left <= 0) begin
                mode     = $urandom_range(0, 2);
                seg_left = $urandom_range(20, 60);
            end
            seg_left--;
            r = $urandom_range(0, 99);
            case (mode)
                0:       c = (r < 40) ? CMD_INSERT : (r < 80) ? CMD_APPEND :
                             (r < 85) ? CMD_DELETE : CMD_READ;
                1:       c = (r < 10) ? CMD_INSERT : (r < 20) ? CMD_APPEND :
                             (r < 75) ? CMD_DELETE : CMD_READ;
                default: c = (r < 25) ? CMD_INSERT : (r < 50) ? CMD_APPEND :
                             (r < 75) ? CMD_DELETE : CMD_READ;
            endcase
            case (c)
                CMD_INSERT: send_item(c, pick_position(shadow_len + 1), pick_value());
                CMD_APPEND: send_item(c, POS_W'($urandom_range(0, 31)), pick_value());
                default:    send_item(c, pick_position(shadow_len), pick_value());
            endcase
        end

        // drain outstanding results, then let the block settle
        i_valid <= 1'b0;
        @(posedge i_clk);
        waited = 0;
        while (pending != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (60) @(posedge i_clk);

        if (mismatches == 0 && pending == 0)
            $display("positional_array_list_tb: done, clean");
        else
            $display("positional_array_list_tb: done, errors");
        $finish;
    end

    // watchdog
    initial begin
        #400000;
        $display("positional_array_list_tb: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/pal_pkg.sv
hw/rtl/pal_ctrl.sv
hw/rtl/pal_dp.sv
hw/rtl/positional_array_list.sv
tb/list_result_checker.sv
tb/positional_array_list_tb.sv
